@@ src/dh_link_transform_macros.svh @@
// assertion macros for the dh link transform block
`ifndef DH_LINK_TRANSFORM_MACROS_SVH
`define DH_LINK_TRANSFORM_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during rst
`define DHLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, quiet during rst
`define DHLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DHLT_ASSERT_IMP(label, ante, cons, msg)
`define DHLT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ src/dhlt_pkg.sv @@
// shared types and constants for the dh link transform
`default_nettype none
package dhlt_pkg;

  localparam int unsigned DH_ANGLE_BITS     = 16;
  localparam int unsigned DH_COEF_FRAC_BITS = 14;

  // taylor terms per sine and cosine
  localparam int unsigned NTERMS = 8;

  // fixed q30 constants of the sine/cosine generator
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // generator depth: two front stages, three per cell, two back stages
  localparam int unsigned SC_LAT = 4 + 3 * NTERMS;

  localparam logic [1:0] MODE_CLASSIC = 2'd0;
  localparam logic [1:0] MODE_CRAIG   = 2'd1;
  localparam logic [1:0] MODE_BETA    = 2'd2;

  // word handed from cell to cell
  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
  } sc_t;

  // per-item fields carried beside the generator
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] len;
    logic signed [31:0] off;
  } side_t;

endpackage
`default_nettype wire

@@ src/dhlt_cell.sv @@
// one horner step of the sine and cosine series
`default_nettype none
module dhlt_cell #(
  parameter int unsigned K_TERM = 1
) (
  input  logic         clk,
  input  logic         en,
  input  dhlt_pkg::sc_t d_in,
  output dhlt_pkg::sc_t d_out
);
  import dhlt_pkg::*;

  localparam int unsigned DS = 2 * K_TERM * (2 * K_TERM + 1);
  localparam int unsigned DC = (2 * K_TERM - 1) * 2 * K_TERM;
  // reciprocals, quotient estimate is floor or floor minus one
  localparam logic [63:0] MS_W = (64'd1 << 32) / DS;
  localparam logic [63:0] MC_W = (64'd1 << 32) / DC;
  localparam logic [31:0] MS = MS_W[31:0];
  localparam logic [31:0] MC = MC_W[31:0];

  sc_t         sa, sb;
  logic [31:0] qs_a, qc_a, qs_b, qc_b, hs_b, hc_b;
  logic [62:0] ps, pc;
  logic [63:0] hs_p, hc_p;
  logic [40:0] rem_s, rem_c;
  logic [31:0] quot_s, quot_c;
  logic signed [32:0] ts_d, tc_d;

  assign ps   = 63'(d_in.x2) * 63'(d_in.ts);
  assign pc   = 63'(d_in.x2) * 63'(d_in.tc);
  assign hs_p = 64'(qs_a) * 64'(MS);
  assign hc_p = 64'(qc_a) * 64'(MC);

  assign rem_s  = 41'(qs_b) - 41'(hs_b) * 41'(DS);
  assign rem_c  = 41'(qc_b) - 41'(hc_b) * 41'(DC);
  assign quot_s = hs_b + 32'(rem_s >= 41'(DS));
  assign quot_c = hc_b + 32'(rem_c >= 41'(DC));
  assign ts_d   = $signed({2'b00, Q30_ONE}) - $signed({1'b0, quot_s});
  assign tc_d   = $signed({2'b00, Q30_ONE}) - $signed({1'b0, quot_c});

  always_ff @(posedge clk) begin
    if (en) begin
      sa    <= d_in;
      qs_a  <= ps[61:30];
      qc_a  <= pc[61:30];
      sb    <= sa;
      qs_b  <= qs_a;
      qc_b  <= qc_a;
      hs_b  <= hs_p[63:32];
      hc_b  <= hc_p[63:32];
      d_out.quad <= sb.quad;
      d_out.x    <= sb.x;
      d_out.x2   <= sb.x2;
      d_out.ts   <= ts_d[30:0];
      // cosine term never goes below zero
      d_out.tc   <= tc_d[32] ? '0 : tc_d[30:0];
    end
  end

endmodule
`default_nettype wire

@@ src/dhlt_sincos.sv @@
// pipelined sine and cosine of one turn-fraction angle
`default_nettype none
module dhlt_sincos #(
  parameter int unsigned ANGLE_BITS     = dhlt_pkg::DH_ANGLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = dhlt_pkg::DH_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [15:0]                      ang,
  output logic signed [COEF_FRAC_BITS+1:0] sin_v,
  output logic signed [COEF_FRAC_BITS+1:0] cos_v
);
  import dhlt_pkg::*;

  localparam int unsigned AW = ANGLE_BITS;
  localparam int unsigned CW = COEF_FRAC_BITS + 2;
  localparam int unsigned SH = 30 - COEF_FRAC_BITS;
  localparam int unsigned XW = AW - 2 + 31;
  localparam logic [31:0] HALF = (32'd1 << SH) >> 1;

  logic [AW-1:0] u;
  logic [XW-1:0] xp;
  logic [1:0]    quad1;
  logic [30:0]   x1;
  logic [61:0]   x2p;
  sc_t           head;
  sc_t           link [NTERMS];
  logic [61:0]   sqp;
  logic [30:0]   sq, tcb;
  logic [1:0]    quadb;
  logic [31:0]   s_sum, c_sum;
  logic [31:0]   s_sh, c_sh;
  logic signed [CW-1:0] s_r, c_r;

  assign u   = AW'(ang);
  assign xp  = XW'(u[AW-3:0]) * XW'(HALF_PI_Q30);
  assign x2p = 62'(x1) * 62'(x1);

  always_ff @(posedge clk) begin
    if (en) begin
      quad1     <= u[AW-1:AW-2];
      x1        <= xp[XW-1:AW-2];
      head.quad <= quad1;
      head.x    <= x1;
      head.x2   <= x2p[61:30];
      head.ts   <= Q30_ONE;
      head.tc   <= Q30_ONE;
    end
  end

  // series cells, highest term first
  for (genvar i = 0; i < NTERMS; i++) begin : g_cell
    if (i == 0) begin : g_first
      dhlt_cell #(.K_TERM(NTERMS - i)) u_cell (
        .clk(clk), .en(en), .d_in(head), .d_out(link[i])
      );
    end else begin : g_rest
      dhlt_cell #(.K_TERM(NTERMS - i)) u_cell (
        .clk(clk), .en(en), .d_in(link[i-1]), .d_out(link[i])
      );
    end
  end

  assign sqp   = 62'(link[NTERMS-1].x) * 62'(link[NTERMS-1].ts);
  assign s_sum = 32'(sq) + HALF;
  assign c_sum = 32'(tcb) + HALF;
  assign s_sh  = s_sum >> SH;
  assign c_sh  = c_sum >> SH;
  assign s_r   = $signed(s_sh[CW-1:0]);
  assign c_r   = $signed(c_sh[CW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      sq    <= sqp[60:30];
      tcb   <= link[NTERMS-1].tc;
      quadb <= link[NTERMS-1].quad;
      case (quadb)
        2'd0: begin
          sin_v <= s_r;
          cos_v <= c_r;
        end
        2'd1: begin
          sin_v <= c_r;
          cos_v <= -s_r;
        end
        2'd2: begin
          sin_v <= -s_r;
          cos_v <= -c_r;
        end
        default: begin
          sin_v <= -c_r;
          cos_v <= s_r;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/dhlt_rmul.sv @@
// registered signed multiply, scaled down with round half away from zero
`default_nettype none
module dhlt_rmul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16,
  parameter int unsigned SH = 14
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);
  localparam int unsigned PW = AW + BW;
  localparam logic [PW-1:0] HALF = (PW'(1) << SH) >> 1;

  logic signed [PW-1:0] v;
  logic [PW-1:0]        mag, rnd;
  logic                 neg;

  assign v   = PW'(a) * PW'(b);
  assign neg = v[PW-1];
  assign mag = neg ? PW'(-v) : PW'(v);
  assign rnd = (mag + HALF) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? -$signed(rnd) : $signed(rnd);
    end
  end

endmodule
`default_nettype wire

@@ src/dh_link_transform.sv @@
// top level of the dh link transform: trig generators, product stages, output
`default_nettype none
`include "dh_link_transform_macros.svh"
// Denavit-Hartenberg link transform. One link word enters per cycle and one
// result word leaves per cycle when nothing stalls: the three sine/cosine
// generators are chains of series cells (eight cells of three stages each,
// plus two front and two back stages), followed by two product stages and
// the output register. The output register is the only point of
// backpressure: while a result waits untaken the whole pipeline holds and
// s_axis_tready is low, otherwise a new word is taken every cycle.
// Mode selects the convention (classic, modified, modified with second
// twist; code three acts as two). Rotation entries are Q2.14
// (COEF_FRAC_BITS fraction bits) clamped to plus or minus one, translations
// are Q16.16 rounded and saturated. No reset sequence is needed beyond the
// reset of the valid flags.
module dh_link_transform #(
  parameter int unsigned ANGLE_BITS     = dhlt_pkg::DH_ANGLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = dhlt_pkg::DH_COEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // link_length, link_twist, second_twist, link_offset, joint_angle
  input  logic [111:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_00 .. rot_22, pos_x, pos_y, pos_z
  output logic [239:0] m_axis_tdata
);
  import dhlt_pkg::*;

  localparam int unsigned CF = COEF_FRAC_BITS;
  localparam int unsigned CW = CF + 2;
  localparam int unsigned LW = 32 + CW;
  localparam logic signed [CW:0] ONE_E = (CW + 1)'(1) << CF;

  // pipeline advance: output register empty or being taken
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [SC_LAT+1:0] vld;

  // trig generators
  logic signed [CW-1:0] sal, cal, sbe, cbe, sth, cth;

  dhlt_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(CF)) u_sc_al (
    .clk(clk), .en(en), .ang(s_axis_tdata[47:32]), .sin_v(sal), .cos_v(cal)
  );
  dhlt_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(CF)) u_sc_be (
    .clk(clk), .en(en), .ang(s_axis_tdata[63:48]), .sin_v(sbe), .cos_v(cbe)
  );
  dhlt_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(CF)) u_sc_th (
    .clk(clk), .en(en), .ang(s_axis_tdata[111:96]), .sin_v(sth), .cos_v(cth)
  );

  // mode and lengths ride beside the generators
  side_t side_d [SC_LAT];
  side_t side1, side2;

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0].mode <= s_axis_tuser;
      side_d[0].len  <= $signed(s_axis_tdata[31:0]);
      side_d[0].off  <= $signed(s_axis_tdata[95:64]);
      for (int i = 1; i < SC_LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
      side1 <= side_d[SC_LAT-1];
      side2 <= side1;
    end
  end

  // first product stage: the two-factor coefficient products that the forms use
  // 0 sth*cal  1 sth*sal  2 cth*cal  3 cth*sal  4 cbe*cth  5 sbe*cth
  // 6 sal*sbe  7 cbe*sth  8 sbe*sth  9 cbe*sal 10 cal*sbe 11 cal*cbe
  logic signed [CW-1:0]   a1 [12];
  logic signed [CW-1:0]   b1 [12];
  logic signed [2*CW-1:0] p1w [12];
  logic signed [CW-1:0]   p1 [12];
  logic signed [CW-1:0]   p1d [12];

  assign a1[0]  = sth;  assign b1[0]  = cal;
  assign a1[1]  = sth;  assign b1[1]  = sal;
  assign a1[2]  = cth;  assign b1[2]  = cal;
  assign a1[3]  = cth;  assign b1[3]  = sal;
  assign a1[4]  = cbe;  assign b1[4]  = cth;
  assign a1[5]  = sbe;  assign b1[5]  = cth;
  assign a1[6]  = sal;  assign b1[6]  = sbe;
  assign a1[7]  = cbe;  assign b1[7]  = sth;
  assign a1[8]  = sbe;  assign b1[8]  = sth;
  assign a1[9]  = cbe;  assign b1[9]  = sal;
  assign a1[10] = cal;  assign b1[10] = sbe;
  assign a1[11] = cal;  assign b1[11] = cbe;

  for (genvar i = 0; i < 12; i++) begin : g_p1
    dhlt_rmul #(.AW(CW), .BW(CW), .SH(CF)) u_mul (
      .clk(clk), .en(en), .a(a1[i]), .b(b1[i]), .p(p1w[i])
    );
    assign p1[i] = CW'(p1w[i]);
  end

  // translation products: len*cth, len*sth, off*(-sal), off*cal
  logic signed [31:0]   la [4];
  logic signed [CW-1:0] lb [4];
  logic signed [LW-1:0] lp [4];
  logic signed [LW-1:0] lpd [4];

  assign la[0] = side_d[SC_LAT-1].len;  assign lb[0] = cth;
  assign la[1] = side_d[SC_LAT-1].len;  assign lb[1] = sth;
  assign la[2] = side_d[SC_LAT-1].off;  assign lb[2] = -sal;
  assign la[3] = side_d[SC_LAT-1].off;  assign lb[3] = cal;

  for (genvar i = 0; i < 4; i++) begin : g_lp
    dhlt_rmul #(.AW(32), .BW(CW), .SH(CF)) u_mul (
      .clk(clk), .en(en), .a(la[i]), .b(lb[i]), .p(lp[i])
    );
  end

  // coefficients held for the later stages
  logic signed [CW-1:0] sal1, cal1, cbe1, sth1, cth1;
  logic signed [CW-1:0] sal2, cal2, sth2, cth2;

  always_ff @(posedge clk) begin
    if (en) begin
      sal1 <= sal;
      cal1 <= cal;
      cbe1 <= cbe;
      sth1 <= sth;
      cth1 <= cth;
      sal2 <= sal1;
      cal2 <= cal1;
      sth2 <= sth1;
      cth2 <= cth1;
      for (int i = 0; i < 12; i++) begin
        p1d[i] <= p1[i];
      end
      for (int i = 0; i < 4; i++) begin
        lpd[i] <= lp[i];
      end
    end
  end

  // second product stage: outer factor of the three-factor terms
  // 0 cal*(cbe*sth)  1 cal*(sbe*sth)  2 cbe*(sal*sth)  3 sal*(sbe*sth)
  logic signed [CW-1:0]   a2 [4];
  logic signed [CW-1:0]   b2 [4];
  logic signed [2*CW-1:0] p2w [4];
  logic signed [CW-1:0]   p2 [4];

  assign a2[0] = cal1;  assign b2[0] = p1[7];
  assign a2[1] = cal1;  assign b2[1] = p1[8];
  assign a2[2] = cbe1;  assign b2[2] = p1[1];
  assign a2[3] = sal1;  assign b2[3] = p1[8];

  for (genvar i = 0; i < 4; i++) begin : g_p2
    dhlt_rmul #(.AW(CW), .BW(CW), .SH(CF)) u_mul (
      .clk(clk), .en(en), .a(a2[i]), .b(b2[i]), .p(p2w[i])
    );
    assign p2[i] = CW'(p2w[i]);
  end

  // sums, selection by mode, clamping
  logic signed [CW:0]   rs [9];
  logic signed [CW-1:0] rot_n [9];
  logic signed [CW-1:0] rot_q [9];
  logic signed [LW-1:0] pw [3];
  logic [31:0]          pos_n [3];
  logic [31:0]          pos_q [3];
  logic [1:0]           out_mode;

  function automatic logic signed [CW:0] ext(input logic signed [CW-1:0] v);
    return (CW + 1)'(v);
  endfunction

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rs[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      pw[i] = '0;
    end
    case (side2.mode)
      MODE_CLASSIC: begin
        rs[0] = ext(cth2);
        rs[1] = -ext(p1d[0]);
        rs[2] = ext(p1d[1]);
        rs[3] = ext(sth2);
        rs[4] = ext(p1d[2]);
        rs[5] = -ext(p1d[3]);
        rs[6] = '0;
        rs[7] = ext(sal2);
        rs[8] = ext(cal2);
        pw[0] = lpd[0];
        pw[1] = lpd[1];
        pw[2] = LW'(side2.off);
      end
      MODE_CRAIG: begin
        rs[0] = ext(cth2);
        rs[1] = -ext(sth2);
        rs[2] = '0;
        rs[3] = ext(p1d[0]);
        rs[4] = ext(p1d[2]);
        rs[5] = -ext(sal2);
        rs[6] = ext(p1d[1]);
        rs[7] = ext(p1d[3]);
        rs[8] = ext(cal2);
        pw[0] = LW'(side2.len);
        pw[1] = lpd[2];
        pw[2] = lpd[3];
      end
      default: begin
        // second twist form, code three included
        rs[0] = ext(p1d[4]);
        rs[1] = -ext(sth2);
        rs[2] = ext(p1d[5]);
        rs[3] = ext(p1d[6]) + ext(p2[0]);
        rs[4] = ext(p1d[2]);
        rs[5] = ext(p2[1]) - ext(p1d[9]);
        rs[6] = ext(p2[2]) - ext(p1d[10]);
        rs[7] = ext(p1d[3]);
        rs[8] = ext(p1d[11]) + ext(p2[3]);
        pw[0] = LW'(side2.len);
        pw[1] = lpd[2];
        pw[2] = lpd[3];
      end
    endcase
    for (int i = 0; i < 9; i++) begin
      if (rs[i] > ONE_E) begin
        rot_n[i] = CW'(ONE_E);
      end else if (rs[i] < -ONE_E) begin
        rot_n[i] = CW'(-ONE_E);
      end else begin
        rot_n[i] = CW'(rs[i]);
      end
    end
    // saturate when bit 31 and the bits above it are not all sign
    for (int i = 0; i < 3; i++) begin
      if ((pw[i][LW-1:31] != '0) && (pw[i][LW-1:31] != '1)) begin
        pos_n[i] = pw[i][LW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        pos_n[i] = pw[i][31:0];
      end
    end
  end

  // valid flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld           <= {vld[SC_LAT:0], s_axis_tvalid};
      m_axis_tvalid <= vld[SC_LAT+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_q    <= rot_n;
      pos_q    <= pos_n;
      out_mode <= side2.mode;
    end
  end

  // entries go out as 16-bit fields
  for (genvar i = 0; i < 9; i++) begin : g_rot_out
    logic signed [47:0] rot_w;
    assign rot_w = 48'(rot_q[i]);
    assign m_axis_tdata[16*i +: 16] = rot_w[15:0];
  end
  assign m_axis_tdata[175:144] = pos_q[0];
  assign m_axis_tdata[207:176] = pos_q[1];
  assign m_axis_tdata[239:208] = pos_q[2];

  // checks
  `DHLT_ASSERT_IMP(a_rot_range, m_axis_tvalid, (rot_q[8] <= CW'(ONE_E)) && (rot_q[8] >= CW'(-ONE_E)), "rotation entry out of range")
  `DHLT_ASSERT_IMP(a_classic_zero, m_axis_tvalid && (out_mode == MODE_CLASSIC), rot_q[6] == '0, "classic form row 2 col 0 not zero")
  `DHLT_ASSERT_NXT(a_hold, !en, $stable(vld), "pipeline moved while stalled")

endmodule
`default_nettype wire
